// ----- src/tldr_pkg.sv -----
package tldr_pkg;

    localparam int LEVEL_W     = 16;
    localparam int NOW_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int SECS_W      = 16;
    localparam int SWEEP_W     = 26;
    localparam int PROD_W      = NOW_W + LEVEL_W;
    localparam int SPAN_PROD_W = SWEEP_W + LEVEL_W;
    localparam int SPAN_FOLD_W = SPAN_PROD_W - LEVEL_W + 1;
    localparam int DIV_LONG    = PROD_W;
    localparam int DIVISOR_W   = SWEEP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_LONG + 1);
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL  = 16'hFFFF;
    localparam logic [BYTE_W-1:0]  BYTE_FULL  = 8'd255;
    localparam logic [9:0]         MS_PER_S   = 10'd1000;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SWEEP,
        OP_BEGIN,
        OP_SPAN_START,
        OP_SPAN_FOLD,
        OP_SPAN,
        OP_DELTA_START,
        OP_DELTA,
        OP_BYTE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic is_start;
        logic is_blocked;
        logic ramping;
        logic div_busy;
        logic span_zero;
    } dp_status_t;

endpackage

// ----- src/tldr_div.sv -----
module tldr_div
    import tldr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIV_LONG-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic                   busy,
    output logic [DIV_LONG-1:0]    quotient
);

    logic [DIV_LONG-1:0]  dq_reg, dq_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    logic [DIVISOR_W:0]   shifted;
    logic                 ge;

    assign shifted = {rem_reg, dq_reg[DIV_LONG-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dq_next   = dividend;
            cnt_next  = DIV_CNT_W'(DIV_LONG);
            rem_next  = '0;
            dvs_next  = divisor;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? DIVISOR_W'(shifted - {1'b0, dvs_reg}) : DIVISOR_W'(shifted);
            dq_next   = {dq_reg[DIV_LONG-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// ----- src/tldr_dp.sv -----
module tldr_dp
    import tldr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_op_t                cmd,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output dp_status_t            status,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // captured input word
    logic                 op_reg, op_next;
    logic [NOW_W-1:0]     now_reg, now_next;
    logic [BYTE_W-1:0]    tgt_reg, tgt_next;
    logic [SECS_W-1:0]    secs_reg, secs_next;
    logic                 blk_reg, blk_next;

    // channel state
    logic [LEVEL_W-1:0]   cur_reg, cur_next;
    logic [LEVEL_W-1:0]   from_reg, from_next;
    logic [LEVEL_W-1:0]   to_reg, to_next;
    logic [NOW_W-1:0]     start_ms_reg, start_ms_next;
    logic [SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic [BYTE_W-1:0]    remb_reg, remb_next;
    logic                 on_reg, on_next;
    logic                 ramp_reg, ramp_next;
    logic                 on_arm_reg, on_arm_next;
    logic                 off_arm_reg, off_arm_next;

    // per-word scratch
    logic [SPAN_PROD_W-1:0] sp_reg, sp_next;
    logic [SPAN_FOLD_W-1:0] fold_reg, fold_next;
    logic [SWEEP_W-1:0]   span_reg, span_next;
    logic                 wrote_reg, wrote_next;
    logic [BYTE_W-1:0]    lbyte_reg, lbyte_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic                 up;
    logic [LEVEL_W-1:0]   room;
    logic [NOW_W-1:0]     elapsed;
    logic [NOW_W-1:0]     mul_a;
    logic [LEVEL_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod;
    logic                 div_start, div_busy;
    logic [DIV_LONG-1:0]  q;
    logic                 reached;
    logic                 ev_on, ev_off;
    logic [LEVEL_W-1:0]   tgt_level;
    logic [LEVEL_W:0]     fold_lo;
    logic [SWEEP_W-1:0]   span_calc;
    logic [BYTE_W-1:0]    hi_byte, lo_byte;

    assign up      = from_reg <= to_reg;
    assign room    = up ? MAX_LEVEL - from_reg : from_reg;
    assign elapsed = now_reg - start_ms_reg;

    // target * MAX_LEVEL / 255 is the target byte repeated in both halves
    assign tgt_level = {tgt_reg, tgt_reg};

    // divide sweep * room by MAX_LEVEL: fold the high half onto the low half twice
    assign fold_lo   = (LEVEL_W+1)'(fold_reg[SPAN_FOLD_W-1:LEVEL_W])
                     + (LEVEL_W+1)'(fold_reg[LEVEL_W-1:0]);
    assign span_calc = sp_reg[SPAN_PROD_W-1:LEVEL_W]
                     + SWEEP_W'(fold_reg[SPAN_FOLD_W-1:LEVEL_W])
                     + SWEEP_W'(fold_lo >= (LEVEL_W+1)'(MAX_LEVEL));

    // level * 255 / MAX_LEVEL is level / 257
    assign hi_byte = cur_reg[LEVEL_W-1:BYTE_W];
    assign lo_byte = cur_reg[BYTE_W-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            OP_SPAN_START: begin
                mul_a = NOW_W'(sweep_reg);
                mul_b = room;
            end
            OP_DELTA_START: begin
                mul_a = elapsed;
                mul_b = room;
            end
            default: begin
            end
        endcase
    end

    assign prod      = {{LEVEL_W{1'b0}}, mul_a} * {{NOW_W{1'b0}}, mul_b};
    assign div_start = cmd == OP_DELTA_START;

    tldr_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend   (prod),
        .divisor    (span_reg),
        .busy       (div_busy),
        .quotient   (q)
    );

    // stop at the target once the step reaches or passes it
    assign reached = up ? ({1'b0, q} + (DIV_LONG+1)'(from_reg)) >= (DIV_LONG+1)'(to_reg)
                        : q >= DIV_LONG'(from_reg - to_reg);

    assign ev_on  = on_reg && on_arm_reg;
    assign ev_off = !on_reg && off_arm_reg;

    always_comb begin
        op_next       = op_reg;
        now_next      = now_reg;
        tgt_next      = tgt_reg;
        secs_next     = secs_reg;
        blk_next      = blk_reg;
        cur_next      = cur_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        start_ms_next = start_ms_reg;
        sweep_next    = sweep_reg;
        remb_next     = remb_reg;
        on_next       = on_reg;
        ramp_next     = ramp_reg;
        on_arm_next   = on_arm_reg;
        off_arm_next  = off_arm_reg;
        sp_next       = sp_reg;
        fold_next     = fold_reg;
        span_next     = span_reg;
        wrote_next    = wrote_reg;
        lbyte_next    = lbyte_reg;
        out_next      = out_reg;
        case (cmd)
            OP_CAPTURE: begin
                op_next    = s_tuser;
                now_next   = s_tdata[31:0];
                tgt_next   = s_tdata[39:32];
                secs_next  = s_tdata[55:40];
                blk_next   = s_tdata[56];
                wrote_next = 1'b0;
            end
            OP_SWEEP: begin
                sweep_next    = SWEEP_W'(secs_reg) * SWEEP_W'(MS_PER_S);
                start_ms_next = now_reg;
                from_next     = cur_reg;
            end
            OP_BEGIN: begin
                to_next   = tgt_level;
                ramp_next = 1'b1;
                on_next   = 1'b1;
                if (tgt_reg != '0) begin
                    remb_next = tgt_reg;
                end
                // zero ramp time: jump to target at once
                if (sweep_reg == '0) begin
                    cur_next   = tgt_level;
                    wrote_next = 1'b1;
                    ramp_next  = 1'b0;
                    if (tgt_level == '0) begin
                        on_next      = 1'b0;
                        on_arm_next  = 1'b1;
                        off_arm_next = 1'b1;
                    end
                end
            end
            OP_SPAN_START: begin
                sp_next = prod[SPAN_PROD_W-1:0];
            end
            OP_SPAN_FOLD: begin
                fold_next = SPAN_FOLD_W'(sp_reg[SPAN_PROD_W-1:LEVEL_W])
                          + SPAN_FOLD_W'(sp_reg[LEVEL_W-1:0]);
            end
            OP_SPAN: begin
                span_next  = span_calc;
                wrote_next = 1'b1;
                if (span_calc == '0) begin
                    cur_next  = to_reg;
                    ramp_next = 1'b0;
                    if (to_reg == '0) begin
                        on_next      = 1'b0;
                        on_arm_next  = 1'b1;
                        off_arm_next = 1'b1;
                    end
                end
            end
            OP_DELTA: begin
                if (reached) begin
                    cur_next  = to_reg;
                    ramp_next = 1'b0;
                    if (to_reg == '0) begin
                        on_next      = 1'b0;
                        on_arm_next  = 1'b1;
                        off_arm_next = 1'b1;
                    end
                end else if (up) begin
                    cur_next = from_reg + q[LEVEL_W-1:0];
                end else begin
                    cur_next = from_reg - q[LEVEL_W-1:0];
                end
            end
            OP_BYTE: begin
                lbyte_next = (lo_byte < hi_byte) ? hi_byte - 1'b1 : hi_byte;
            end
            OP_OUT: begin
                if (ev_on) begin
                    on_arm_next = 1'b0;
                end
                if (ev_off) begin
                    off_arm_next = 1'b0;
                end
                out_next = M_TDATA_W'({ev_off, ev_on, ramp_reg, on_reg, remb_reg,
                                       lbyte_reg, wrote_reg, cur_reg});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        now_reg   <= now_next;
        tgt_reg   <= tgt_next;
        secs_reg  <= secs_next;
        blk_reg   <= blk_next;
        sp_reg    <= sp_next;
        fold_reg  <= fold_next;
        span_reg  <= span_next;
        wrote_reg <= wrote_next;
        lbyte_reg <= lbyte_next;
        out_reg   <= out_next;
        if (!aresetn) begin
            cur_reg      <= '0;
            from_reg     <= '0;
            to_reg       <= '0;
            start_ms_reg <= '0;
            sweep_reg    <= '0;
            remb_reg     <= '0;
            on_reg       <= 1'b0;
            ramp_reg     <= 1'b0;
            on_arm_reg   <= 1'b1;
            off_arm_reg  <= 1'b0;
        end else begin
            cur_reg      <= cur_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
            start_ms_reg <= start_ms_next;
            sweep_reg    <= sweep_next;
            remb_reg     <= remb_next;
            on_reg       <= on_next;
            ramp_reg     <= ramp_next;
            on_arm_reg   <= on_arm_next;
            off_arm_reg  <= off_arm_next;
        end
    end

    assign status.is_start   = op_reg;
    assign status.is_blocked = blk_reg;
    assign status.ramping    = ramp_reg;
    assign status.div_busy   = div_busy;
    assign status.span_zero  = span_calc == '0;
    assign m_tdata           = out_reg;

endmodule

// ----- src/tldr_ctrl.sv -----
module tldr_ctrl
    import tldr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_op_t     cmd
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_DISPATCH  = 11'b00000000010,
        ST_SWEEP     = 11'b00000000100,
        ST_BEGIN     = 11'b00000001000,
        ST_SPAN_MUL  = 11'b00000010000,
        ST_SPAN_FOLD = 11'b00000100000,
        ST_SPAN      = 11'b00001000000,
        ST_DELTA_MUL = 11'b00010000000,
        ST_DELTA_DIV = 11'b00100000000,
        ST_BYTE      = 11'b01000000000,
        ST_OUT       = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   slot_free;

    assign slot_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cmd         = OP_NONE;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.is_start && !status.is_blocked) begin
                    state_next = ST_SWEEP;
                end else if (!status.is_start && status.ramping) begin
                    state_next = ST_SPAN_MUL;
                end else begin
                    state_next = ST_BYTE;
                end
            end
            ST_SWEEP: begin
                cmd        = OP_SWEEP;
                state_next = ST_BEGIN;
            end
            ST_BEGIN: begin
                cmd        = OP_BEGIN;
                state_next = ST_BYTE;
            end
            ST_SPAN_MUL: begin
                cmd        = OP_SPAN_START;
                state_next = ST_SPAN_FOLD;
            end
            ST_SPAN_FOLD: begin
                cmd        = OP_SPAN_FOLD;
                state_next = ST_SPAN;
            end
            ST_SPAN: begin
                cmd        = OP_SPAN;
                state_next = status.span_zero ? ST_BYTE : ST_DELTA_MUL;
            end
            ST_DELTA_MUL: begin
                cmd        = OP_DELTA_START;
                state_next = ST_DELTA_DIV;
            end
            ST_DELTA_DIV: begin
                if (!status.div_busy) begin
                    cmd        = OP_DELTA;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE: begin
                cmd        = OP_BYTE;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the word
                if (slot_free) begin
                    cmd         = OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = mvalid_reg;

endmodule

// ----- src/timed_linear_dimming_ramp.sv -----
// Steps per word: a tick while idle or a blocked start passes dispatch, byte and out;
// a start adds sweep and begin; a ramp tick adds span multiply, fold and span, then,
// unless the span is zero, delta multiply and the ramp step divider (one quotient bit
// per cycle, 48 bits). Throughput: one word at a time, the next taken the cycle after
// the result is loaded into the output register, which holds it until the sink takes it.
// Reset (aresetn low, synchronous) clears level and ramp state and arms the on event.
module timed_linear_dimming_ramp
    import tldr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] now_ms, [39:32] target_byte, [55:40] ramp_seconds, [56] blocked
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] level, [16] level_write, [24:17] level_byte, [32:25] last_on_byte,
    // [33] is_on, [34] is_ramping, [35] turned_on, [36] turned_off
    output logic [M_TDATA_W-1:0]  m_tdata
);

    dp_op_t     cmd;
    dp_status_t status;

    tldr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tldr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

// ----- sim/testbench.sv -----
module testbench
    import tldr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 450;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } dim_cmd_e;

    typedef struct {
        dim_cmd_e          op;
        logic [NOW_W-1:0]  now;
        logic [BYTE_W-1:0] target;
        logic [SECS_W-1:0] secs;
        logic              blocked;
        logic              drain;
        int unsigned       gap;
    } dim_cmd_t;

    // same bit order as m_tdata, lowest field last
    typedef struct packed {
        logic               turned_off;
        logic               turned_on;
        logic               is_ramping;
        logic               is_on;
        logic [BYTE_W-1:0]  last_on_byte;
        logic [BYTE_W-1:0]  level_byte;
        logic               level_write;
        logic [LEVEL_W-1:0] level;
    } dim_report_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] now_ms, [39:32] target_byte, [55:40] ramp_seconds, [56] blocked
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] operation
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [15:0] level, [16] level_write, [24:17] level_byte, [32:25] last_on_byte,
    // [33] is_on, [34] is_ramping, [35] turned_on, [36] turned_off
    logic [M_TDATA_W-1:0] m_tdata;

    timed_linear_dimming_ramp dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // dimmer state as the block should hold it
    logic [LEVEL_W-1:0] lvl         = '0;
    logic [LEVEL_W-1:0] from_lvl    = '0;
    logic [LEVEL_W-1:0] to_lvl      = '0;
    logic [NOW_W-1:0]   start_ms    = '0;
    logic [SWEEP_W-1:0] sweep_ms    = '0;
    logic [BYTE_W-1:0]  last_on     = '0;
    logic               lit         = 1'b0;
    logic               ramping     = 1'b0;
    logic               on_armed    = 1'b1;
    logic               off_armed   = 1'b0;

    dim_cmd_t    cmd_q[$];
    dim_report_t report_q[$];
    dim_cmd_t    in_flight;
    int unsigned gap_left   = 0;
    logic        gap_loaded = 1'b0;
    logic        tx_burst   = 1'b0;
    logic        rx_burst   = 1'b0;
    int unsigned stall_left = 0;
    int unsigned live_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned errors     = 0;

    function automatic void settle_at_target();
        lvl = to_lvl;
        ramping = 1'b0;
        if (lvl == '0) begin
            lit = 1'b0;
            on_armed = 1'b1;
            off_armed = 1'b1;
        end
    endfunction

    function automatic dim_report_t ramp_update(dim_cmd_t c);
        dim_report_t      r;
        logic             wrote;
        logic             reached;
        logic [NOW_W-1:0] gone;
        logic [63:0]      elapsed;
        logic [63:0]      room;
        logic [63:0]      span;
        logic [63:0]      delta;
        wrote = 1'b0;
        reached = 1'b0;
        r = '0;
        if (c.op == CMD_START) begin
            if (!c.blocked) begin
                sweep_ms = SWEEP_W'(32'(c.secs) * 32'(MS_PER_S));
                start_ms = c.now;
                from_lvl = lvl;
                to_lvl = LEVEL_W'(32'(c.target) * 32'(MAX_LEVEL) / 32'(BYTE_FULL));
                ramping = 1'b1;
                lit = 1'b1;
                if (c.target != '0)
                    last_on = c.target;
                if (sweep_ms == '0) begin
                    settle_at_target();
                    wrote = 1'b1;
                end
            end
        end else if (ramping) begin
            wrote = 1'b1;
            gone = c.now - start_ms;
            elapsed = 64'(gone);
            if (from_lvl <= to_lvl) begin
                room = 64'(MAX_LEVEL) - 64'(from_lvl);
                span = 64'(sweep_ms) * room / 64'(MAX_LEVEL);
                if (span == 0) begin
                    reached = 1'b1;
                end else begin
                    delta = elapsed * room / span;
                    if (64'(from_lvl) + delta >= 64'(to_lvl))
                        reached = 1'b1;
                    else
                        lvl = from_lvl + delta[LEVEL_W-1:0];
                end
            end else begin
                span = 64'(sweep_ms) * 64'(from_lvl) / 64'(MAX_LEVEL);
                if (span == 0) begin
                    reached = 1'b1;
                end else begin
                    delta = elapsed * 64'(from_lvl) / span;
                    if (delta >= 64'(from_lvl - to_lvl))
                        reached = 1'b1;
                    else
                        lvl = from_lvl - delta[LEVEL_W-1:0];
                end
            end
            if (reached)
                settle_at_target();
        end
        // one-shot events look at the state after the update
        if (lit && on_armed) begin
            on_armed = 1'b0;
            r.turned_on = 1'b1;
        end
        if (!lit && off_armed) begin
            off_armed = 1'b0;
            r.turned_off = 1'b1;
        end
        r.level        = lvl;
        r.level_write  = wrote;
        r.level_byte   = BYTE_W'(32'(lvl) * 32'(BYTE_FULL) / 32'(MAX_LEVEL));
        r.last_on_byte = last_on;
        r.is_on        = lit;
        r.is_ramping   = ramping;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    task automatic push_cmd(dim_cmd_e op, logic [NOW_W-1:0] now, logic [BYTE_W-1:0] target,
                            logic [SECS_W-1:0] secs, logic blocked, logic drain);
        dim_cmd_t c;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        c.op      = op;
        c.now     = now;
        c.target  = target;
        c.secs    = secs;
        c.blocked = blocked;
        c.drain   = drain;
        c.gap     = tx_burst ? 0 : $urandom_range(0, 3);
        cmd_q.push_back(c);
        live_cnt++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin : drive
        logic held_back;
        held_back = s_tvalid && !s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                report_q.push_back(ramp_update(in_flight));
            if (!held_back) begin
                if (cmd_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    if (!gap_loaded) begin
                        gap_left = cmd_q[0].gap;
                        gap_loaded = 1'b1;
                    end
                    if (gap_left != 0) begin
                        gap_left--;
                        s_tvalid <= 1'b0;
                    end else if (cmd_q[0].drain && report_q.size() != 0) begin
                        // hold off until every word in flight has come back
                        s_tvalid <= 1'b0;
                    end else begin
                        in_flight = cmd_q.pop_front();
                        gap_loaded = 1'b0;
                        s_tvalid <= 1'b1;
                        s_tuser  <= in_flight.op;
                        s_tdata  <= S_TDATA_W'({in_flight.blocked, in_flight.secs,
                                                in_flight.target, in_flight.now});
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        dim_report_t want;
        dim_report_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(dim_report_t)-1:0];
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = report_q.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("level_write", want.level_write, got.level_write);
                    check_field("level_byte", want.level_byte, got.level_byte);
                    check_field("last_on_byte", want.last_on_byte, got.last_on_byte);
                    check_field("is_on", want.is_on, got.is_on);
                    check_field("is_ramping", want.is_ramping, got.is_ramping);
                    check_field("turned_on", want.turned_on, got.turned_on);
                    check_field("turned_off", want.turned_off, got.turned_off);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 3);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [NOW_W-1:0]  ms;
        logic [BYTE_W-1:0] tgt;
        logic [SECS_W-1:0] secs;

        // idle tick, blocked start, immediate full and immediate off
        push_cmd(CMD_TICK,  32'd0,  8'd0,   16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd7,  8'd255, 16'd0, 1'b1, 1'b0);
        push_cmd(CMD_START, 32'd9,  8'd255, 16'd0, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd10, 8'd0,   16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd11, 8'd0,   16'd0, 1'b0, 1'b0);
        // timed ramp up, blocked start during it, then overshoot
        push_cmd(CMD_START, 32'd100,  8'd200, 16'd1, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd600,  8'd0,   16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd700,  8'd9,   16'd3, 1'b1, 1'b0);
        push_cmd(CMD_TICK,  32'd1100, 8'd0,   16'd0, 1'b0, 1'b0);
        // longest sweep, time wrapping across zero, then the largest elapsed time
        push_cmd(CMD_START, 32'hFFFF_FF00, 8'd1,  16'hFFFF, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'h0000_1000, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
        push_cmd(CMD_TICK,  32'hFFFF_FEFF, 8'd0,  16'd0,    1'b0, 1'b0);
        // zero target keeps the remembered byte
        push_cmd(CMD_START, 32'd0, 8'd0, 16'd0, 1'b0, 1'b0);
        // climb near full, then a restart whose span truncates to zero
        push_cmd(CMD_START, 32'd0,    8'd255, 16'd2, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd1999, 8'd0,   16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd2000, 8'd255, 16'd1, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd2001, 8'd0,   16'd0, 1'b0, 1'b0);
        // same from the bottom on a down ramp, ending switched off
        push_cmd(CMD_START, 32'd3000, 8'd0, 16'd2, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd4999, 8'd0, 16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd5000, 8'd0, 16'd1, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd5001, 8'd0, 16'd0, 1'b0, 1'b0);
        // mid-ramp reversal overshooting below zero
        push_cmd(CMD_START, 32'd6000,  8'd128, 16'd1, 1'b0, 1'b1);
        push_cmd(CMD_TICK,  32'd6500,  8'd0,   16'd0, 1'b0, 1'b0);
        push_cmd(CMD_START, 32'd6600,  8'd0,   16'd1, 1'b0, 1'b0);
        push_cmd(CMD_TICK,  32'd20000, 8'd0,   16'd0, 1'b0, 1'b0);

        ms = $urandom;
        while (live_cnt < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push_cmd(dim_cmd_e'($urandom_range(0, 1)), $urandom, BYTE_W'($urandom),
                         SECS_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            end else begin
                case ($urandom_range(0, 3))
                    0: tgt = '0;
                    1: tgt = BYTE_FULL;
                    default: tgt = BYTE_W'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: secs = '0;
                    1: secs = SECS_W'($urandom);
                    default: secs = SECS_W'($urandom_range(1, 4));
                endcase
                push_cmd(CMD_START, ms, tgt, secs, $urandom_range(0, 7) == 0, 1'b0);
                repeat ($urandom_range(1, 6)) begin
                    ms = ms + $urandom_range(0, 1500);
                    push_cmd(CMD_TICK, ms, BYTE_W'($urandom), SECS_W'($urandom),
                             1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
                end
            end
            if ($urandom_range(0, 19) == 0)
                ms = $urandom;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (cmd_q.size() == 0 && !s_tvalid && report_q.size() == 0);
        repeat (200) @(posedge aclk);

        if (report_q.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, report_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
